### src/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;
	localparam int COLOR_W = 4;

	localparam logic [0:0] OP_PUT  = 1'b0;
	localparam logic [0:0] OP_READ = 1'b1;

	localparam logic [0:0] REG_FG = 1'b0;
	localparam logic [0:0] REG_BG = 1'b1;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'h20;
	localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'h7E;
	localparam int                TAB_STEP   = 8;
	localparam logic [CELL_W-1:0] RESET_CELL = 16'h0220;

	typedef enum logic [2:0] {
		K_PRINT   = 3'd0,
		K_NEWLINE = 3'd1,
		K_TAB     = 3'd2,
		K_IGNORE  = 3'd3,
		K_READ    = 3'd4
	} tcw_kind_t;

	typedef struct packed {
		logic [0:0]        opcode;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} tcw_req_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [CELL_W-1:0] cell_value;
	} tcw_rsp_t;

	typedef struct packed {
		tcw_kind_t         kind;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} tcw_item_t;

	typedef struct packed {
		logic      valid;
		tcw_item_t item;
	} tcw_head_t;

	typedef struct packed {
		logic pop;
		logic init_busy;
	} tcw_ctl_t;

	typedef struct packed {
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
	} tcw_colors_t;

endpackage

### src/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/tcw_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
module tcw_front import tcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  tcw_req_t  req,
	output tcw_head_t head,
	input  tcw_ctl_t  ctl
);

	localparam int DEPTH = 2;
	localparam int PTR_W = 1;
	localparam int CNT_W = 2;

	tcw_item_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	tcw_item_t        item;
	logic             push;
	logic             full;

	always_comb begin
		item.char_code  = req.char_code;
		item.cell_index = req.cell_index;
		case (req.opcode)
			OP_READ: begin
				item.kind = K_READ;
			end
			OP_PUT: begin
				if (req.char_code == CH_NEWLINE) begin
					item.kind = K_NEWLINE;
				end else if (req.char_code == CH_TAB) begin
					item.kind = K_TAB;
				end else if (req.char_code >= PRINT_LOW && req.char_code <= PRINT_HIGH) begin
					item.kind = K_PRINT;
				end else begin
					item.kind = K_IGNORE;
				end
			end
			default: begin
				item.kind = K_IGNORE;
			end
		endcase
	end

	assign full      = (count_q == CNT_W'(DEPTH));
	assign req_stall = full || ctl.init_busy;
	assign push      = req_valid && !req_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, ctl.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

endmodule

### src/tcw_back.sv
// Back end: cursor, screen memory with row ring, scroll clear and result register.
module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tcw_head_t   head,
	output tcw_ctl_t    ctl,
	input  tcw_colors_t colors,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output tcw_rsp_t    rsp
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SUM_W  = ADDR_W + 1;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int TAB_W  = COL_W + 4;

	typedef enum logic [4:0] {
		S_INIT = 5'b00001,
		S_IDLE = 5'b00010,
		S_EXEC = 5'b00100,
		S_RDW  = 5'b01000,
		S_CLR  = 5'b10000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	tcw_item_t         item_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] lbase_q;
	logic [ADDR_W-1:0] prow_q;
	logic [ADDR_W-1:0] top_q;
	logic [ADDR_W-1:0] addr_q;
	logic [COL_W-1:0]  cnt_q;
	logic              out_valid_q;
	tcw_rsp_t          out_q;

	logic              out_free;
	logic              load;
	logic [TAB_W-1:0]  col_tab;
	logic              wrap;
	logic              last_row;
	logic              scroll;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;
	logic [ADDR_W-1:0] nxt_lbase;
	logic [ADDR_W-1:0] nxt_prow;
	logic [SUM_W-1:0]  prow_sum;
	logic [ADDR_W-1:0] prow_step;
	logic [SUM_W-1:0]  top_sum;
	logic [ADDR_W-1:0] top_step;
	logic [ADDR_W-1:0] pos_full;
	logic              in_range;
	logic [SUM_W-1:0]  rd_sum;
	logic [ADDR_W-1:0] rd_addr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [CELL_W-1:0] rdata;

	tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_screen (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign out_free = !out_valid_q || !rsp_stall;

	// Physical row bases advance around the ring of ROWS rows.
	assign prow_sum  = SUM_W'(prow_q) + SUM_W'(COLUMNS);
	assign prow_step = (prow_sum >= SUM_W'(CELLS)) ? ADDR_W'(prow_sum - SUM_W'(CELLS))
	                                               : ADDR_W'(prow_sum);
	assign top_sum   = SUM_W'(top_q) + SUM_W'(COLUMNS);
	assign top_step  = (top_sum >= SUM_W'(CELLS)) ? ADDR_W'(top_sum - SUM_W'(CELLS))
	                                             : ADDR_W'(top_sum);

	assign col_tab  = TAB_W'(col_q) + TAB_W'(TAB_STEP);
	assign last_row = (row_q == ROW_W'(ROWS - 1));

	always_comb begin
		wrap      = 1'b0;
		nxt_col   = col_q;
		nxt_row   = row_q;
		nxt_lbase = lbase_q;
		nxt_prow  = prow_q;
		case (item_q.kind)
			K_NEWLINE: begin
				wrap = 1'b1;
			end
			K_TAB: begin
				if (col_tab >= TAB_W'(COLUMNS)) begin
					wrap = 1'b1;
				end else begin
					nxt_col = COL_W'(col_tab);
				end
			end
			K_PRINT: begin
				if (col_q == COL_W'(COLUMNS - 1)) begin
					wrap = 1'b1;
				end else begin
					nxt_col = col_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (wrap) begin
			nxt_col = '0;
			if (last_row) begin
				// The old top row becomes the new bottom row.
				nxt_prow = top_q;
			end else begin
				nxt_row   = row_q + 1'b1;
				nxt_lbase = lbase_q + ADDR_W'(COLUMNS);
				nxt_prow  = prow_step;
			end
		end
	end

	assign scroll   = wrap && last_row;
	assign pos_full = nxt_lbase + ADDR_W'(nxt_col);

	assign in_range = (int'(item_q.cell_index) < CELLS);
	assign rd_sum   = SUM_W'(ADDR_W'(item_q.cell_index)) + SUM_W'(top_q);
	assign rd_addr  = (rd_sum >= SUM_W'(CELLS)) ? ADDR_W'(rd_sum - SUM_W'(CELLS))
	                                           : ADDR_W'(rd_sum);

	always_comb begin
		state_d       = state_q;
		ctl.pop       = 1'b0;
		ctl.init_busy = (state_q == S_INIT);
		load          = 1'b0;
		we            = 1'b0;
		waddr         = addr_q;
		wdata         = '0;
		re            = 1'b0;
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				wdata = RESET_CELL;
				if (addr_q == ADDR_W'(CELLS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (head.valid) begin
					ctl.pop = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (item_q.kind == K_READ && in_range) begin
					re      = 1'b1;
					state_d = S_RDW;
				end else if (out_free) begin
					load  = 1'b1;
					we    = (item_q.kind == K_PRINT);
					waddr = prow_q + ADDR_W'(col_q);
					wdata = {colors.bg, colors.fg, item_q.char_code};
					state_d = scroll ? S_CLR : S_IDLE;
				end
			end
			S_RDW: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_CLR: begin
				we = 1'b1;
				if (cnt_q == COL_W'(COLUMNS - 1)) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			item_q <= head.item;
		end
		if (load) begin
			out_q.cursor_pos <= POS_W'(pos_full);
			out_q.cell_value <= (state_q == S_RDW) ? rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			col_q       <= '0;
			row_q       <= '0;
			lbase_q     <= '0;
			prow_q      <= '0;
			top_q       <= '0;
			addr_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_INIT || state_q == S_CLR) begin
				addr_q <= addr_q + 1'b1;
				cnt_q  <= cnt_q + 1'b1;
			end
			if (load && state_q == S_EXEC) begin
				col_q   <= nxt_col;
				row_q   <= nxt_row;
				lbase_q <= nxt_lbase;
				prow_q  <= nxt_prow;
				if (scroll) begin
					top_q  <= top_step;
					addr_q <= top_q;
					cnt_q  <= '0;
				end
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

### src/text_console_writer.sv
// Top level of the text console writer: register port, front end and back end.
//
// Request beats (req_valid, req_stall, req) carry a put of one byte or a read of
// one screen cell. Every request gives exactly one response beat (rsp_valid,
// rsp_stall, rsp) with the cursor position after it and, for a read, the cell.
// Colors for written cells come from two registers on the APB-style port:
// fg_color at byte address 0 and bg_color at byte address 4.
// A request passes a two-entry queue; the back end pops it into its item
// register, executes it and loads the response register, and a read first
// waits on the screen memory's read port. The sequencer in the back end takes
// a new request from the queue only after it is through with the last one,
// and waits while the response register is still held. A put that scrolls
// the screen then sweeps the new bottom row to zero before another is popped.
// After reset the screen memory is filled with green spaces on black, one cell
// a cycle; req_stall is high during that pass. While the receiver stalls, the
// response register holds its beat, the back end waits, and up to three
// further requests are still taken: one in the back end and two in the queue.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  tcw_req_t    req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output tcw_rsp_t    rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CELLS = COLUMNS * ROWS;

	// Color registers; the register index is the word address bit.
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic               cfg_write;
	tcw_colors_t        colors;
	tcw_head_t          head;
	tcw_ctl_t           ctl;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'd2;
			bg_q <= 4'd0;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_FG:  fg_q <= pwdata[COLOR_W-1:0];
				REG_BG:  bg_q <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FG:  prdata = 32'(fg_q);
			REG_BG:  prdata = 32'(bg_q);
			default: prdata = '0;
		endcase
	end

	assign colors.fg = fg_q;
	assign colors.bg = bg_q;

	// The front end classifies each byte and queues it; it refuses beats while
	// the queue is full or the screen is still being filled after reset.
	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.head      (head),
		.ctl       (ctl)
	);

	// The back end owns the cursor and the screen memory. Rows live in a ring,
	// so a scroll only moves the top-row and cursor-row bases and clears one row.
	tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.ctl       (ctl),
		.colors    (colors),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	// No request beat may be taken while the fill pass after reset runs.
	assert property (@(posedge clk) disable iff (!arst_n) ctl.init_busy |-> req_stall)
		else $error("request accepted during screen fill");

	// The back end pops only an occupied queue.
	assert property (@(posedge clk) disable iff (!arst_n) ctl.pop |-> head.valid)
		else $error("queue popped while empty");

	// The reported cursor always lies on the screen; the check is skipped above 2048 cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((int'(rsp.cursor_pos) < CELLS) || (CELLS > 2048)))
		else $error("cursor position beyond the screen");
`endif

endmodule
